### design/bcsh_pkg.sv
// ----------------------------------------------------------------------------
// Bitcrusher package
// Widths, constants and the request/response types of the shared divider.
// ----------------------------------------------------------------------------
package bcsh_pkg;

	// Field and register widths.
	localparam int SAMPLE_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int HOLD_W     = 16;
	localparam int DEPTH_W    = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Datapath widths.
	localparam int PROD_W = 50;
	localparam int ACC_W  = 42;
	localparam int MAG_W  = 25;
	localparam int LIM_W  = 32;

	// Shared divider widths.
	localparam int DIV_RW    = 33;
	localparam int DIV_QW    = 25;
	localparam int DIV_CNT_W = 5;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FACTOR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN    = 8'd3;

	// Register reset values.
	localparam logic [HOLD_W-1:0]  RST_HOLD_FACTOR = 16'd1;
	localparam logic [DEPTH_W-1:0] RST_BIT_DEPTH   = 5'd8;
	localparam logic [GAIN_W-1:0]  RST_DRY_GAIN    = 16'd19661;
	localparam logic [GAIN_W-1:0]  RST_WET_GAIN    = 16'd29491;

	// Quantizer constants.
	localparam logic [DEPTH_W-1:0]  MAX_DEPTH = 5'd24;
	localparam logic [SAMPLE_W-1:0] Q23_MAX   = 24'h7FFFFF;
	localparam logic [47:0]         Q_ROUND   = 48'h800000;

	// Trim 0.95 = 95/100 and limiter 0.6 folded: 95*m*2^22 / (100*2^23 + 57*m).
	localparam logic [LIM_W-1:0] TRIM_NUM  = 32'd95;
	localparam logic [LIM_W-1:0] LIM_K     = 32'd57;
	localparam logic [LIM_W-1:0] LIM_BASE  = 32'd838860800;
	localparam logic [ACC_W-1:0] MIX_ROUND = 42'h4000;

	// Step counts of the two divisions.
	localparam logic [DIV_CNT_W-1:0] CRUSH_STEPS = 5'd25;
	localparam logic [DIV_CNT_W-1:0] LIMIT_STEPS = 5'd23;

	// Request into the shared divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
		logic [DIV_RW-1:0]    rem0;
		logic [DIV_RW-1:0]    divisor;
		logic [DIV_QW-1:0]    low;
	} div_req_t;

	// Status and result of the shared divider.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_QW-1:0] quo;
	} div_rsp_t;

endpackage

### design/bcsh_div.sv
// ----------------------------------------------------------------------------
// Bitcrusher shared divider
// Restoring divider that develops one quotient bit per cycle. The caller
// preloads the upper dividend bits as the starting remainder and supplies the
// lower dividend bits left-aligned; they are shifted in one per step.
// ----------------------------------------------------------------------------
module bcsh_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bcsh_pkg::div_req_t req,
	output bcsh_pkg::div_rsp_t rsp
);
	import bcsh_pkg::*;

	logic [DIV_RW-1:0]    rem_q;
	logic [DIV_RW-1:0]    div_q;
	logic [DIV_QW-1:0]    low_q;
	logic [DIV_QW-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_RW:0] trial;
	logic [DIV_RW:0] diff;
	logic            fits;

	// One trial subtraction per cycle.
	assign trial = {rem_q, low_q[DIV_QW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, divisor and quotient registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			div_q <= req.divisor;
			low_q <= req.low;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
			low_q <= {low_q[DIV_QW-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QW-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// The remainder must stay below the divisor for the quotient to fit.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < div_q))
		else $error("divider remainder reached the divisor");

	// Completion is a single-cycle pulse.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

	// A start always leads to a running division.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider did not start");

endmodule

### design/bitcrusher_sample_hold_mix.sv
// ----------------------------------------------------------------------------
// Bitcrusher with sample-and-hold and dry/wet mix
// Quantizes and holds a Q1.23 sample, mixes it with the dry sample, trims by
// 0.95 and soft-limits with x/(1+0.6|x|), giving a Q2.22 result.
//
//   Channel  Signals                            Direction  Transaction
//   src      src_valid, src_stall, sample_in    in         one input sample
//   dst      dst_valid, dst_stall, sample_out   out        one output sample
//   cfg      cfg_valid, cfg_ready, cfg_index,   in         one register write
//            cfg_data
//
// A refreshed sample passes through the quantizer and limiter divisions, a held
// sample through the limiter division only; both run on the shared divider,
// which produces one quotient bit per cycle (25 steps for the quantizer, 23
// for the limiter). src_stall is low only while the sequencer is idle.
// The output register holds a finished sample while dst_stall is high, and
// the next sample is already accepted and worked on meanwhile.
// Reset clears the control state, the hold counter, the held value and
// restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitcrusher_sample_hold_mix (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   src_valid,
	output logic                                   src_stall,
	input  logic signed [bcsh_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                   dst_valid,
	input  logic                                   dst_stall,
	output logic signed [bcsh_pkg::SAMPLE_W-1:0]   sample_out,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [bcsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [bcsh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bcsh_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_QMUL = 12'b0000_0000_0010,
		ST_QLD  = 12'b0000_0000_0100,
		ST_QDIV = 12'b0000_0000_1000,
		ST_MDRY = 12'b0000_0001_0000,
		ST_MWET = 12'b0000_0010_0000,
		ST_MSUM = 12'b0000_0100_0000,
		ST_MRND = 12'b0000_1000_0000,
		ST_LPRE = 12'b0001_0000_0000,
		ST_LDIV = 12'b0010_0000_0000,
		ST_DONE = 12'b0100_0000_0000,
		ST_SPARE = 12'b1000_0000_0000
	} state_t;

	localparam logic signed [SAMPLE_W-1:0] OUT_PEAK = 24'sd6990507;

	state_t state_q;
	state_t state_d;

	logic [HOLD_W-1:0]  hold_factor_q;
	logic [DEPTH_W-1:0] bit_depth_q;
	logic [GAIN_W-1:0]  dry_gain_q;
	logic [GAIN_W-1:0]  wet_gain_q;

	logic [HOLD_W-1:0]          hold_count_q;
	logic signed [SAMPLE_W-1:0] held_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [SAMPLE_W-1:0]        lv_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       neg_q;
	logic [MAG_W-1:0]           m_q;
	logic [SAMPLE_W-1:0]        res_q;
	logic [SAMPLE_W-1:0]        sample_out_q;
	logic                       dst_valid_q;

	logic                     src_take;
	logic                     out_free;
	logic [DEPTH_W-1:0]       bits;
	logic [SAMPLE_W-1:0]      lv;
	logic signed [MAG_W-1:0]  mul_a;
	logic signed [MAG_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [47:0]              qsum;
	logic [ACC_W-1:0]         mag;
	logic [ACC_W-1:0]         rnd;
	logic [LIM_W-1:0]         den;
	logic [LIM_W-1:0]         num95;
	logic [SAMPLE_W-2:0]      y;
	logic [SAMPLE_W-1:0]      res;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	// Handshake terms.
	assign src_stall = (state_q != ST_IDLE);
	assign src_take  = src_valid && !src_stall;
	assign out_free  = !dst_valid_q || !dst_stall;
	assign cfg_ready = 1'b1;
	assign dst_valid  = dst_valid_q;
	assign sample_out = sample_out_q;

	// Quantizer level count from the clamped bit depth.
	always_comb begin
		if (bit_depth_q == '0) begin
			bits = DEPTH_W'(1);
		end else if (bit_depth_q > MAX_DEPTH) begin
			bits = MAX_DEPTH;
		end else begin
			bits = bit_depth_q;
		end
		lv = ~({SAMPLE_W{1'b1}} << bits);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_QMUL: begin
				mul_a = {1'b0, ~x_q[SAMPLE_W-1], x_q[SAMPLE_W-2:0]};
				mul_b = {1'b0, lv_q};
			end
			ST_MDRY: begin
				mul_a = {{(MAG_W-GAIN_W){1'b0}}, dry_gain_q};
				mul_b = {x_q[SAMPLE_W-1], x_q};
			end
			ST_MWET: begin
				mul_a = {{(MAG_W-GAIN_W){1'b0}}, wet_gain_q};
				mul_b = {held_q[SAMPLE_W-1], held_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Quantized level index and mix magnitude rounding.
	assign qsum = prod_q[47:0] + Q_ROUND;
	assign mag  = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
	assign rnd  = mag + MIX_ROUND;

	// Limiter operands: divisor half and the upper dividend bits.
	assign den   = LIM_BASE + LIM_W'(m_q) * LIM_K;
	assign num95 = LIM_W'(m_q) * TRIM_NUM;

	// Signed result from the limiter quotient.
	assign y   = div_rsp.quo[SAMPLE_W-2:0];
	assign res = neg_q ? (SAMPLE_W'(0) - {1'b0, y}) : {1'b0, y};

	// Divider requests.
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_QLD: begin
				div_req.start   = 1'b1;
				div_req.steps   = CRUSH_STEPS;
				div_req.rem0    = DIV_RW'(qsum[47:24]);
				div_req.divisor = DIV_RW'({lv_q, 1'b0});
				div_req.low     = {1'b0, lv_q};
			end
			ST_LPRE: begin
				div_req.start   = 1'b1;
				div_req.steps   = LIMIT_STEPS;
				div_req.rem0    = {1'b0, num95} + DIV_RW'(den[LIM_W-1:23]);
				div_req.divisor = {den, 1'b0};
				div_req.low     = {den[22:0], 2'b00};
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	bcsh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (src_take) begin
					state_d = (hold_count_q == '0) ? ST_QMUL : ST_MDRY;
				end
			end
			ST_QMUL: state_d = ST_QLD;
			ST_QLD:  state_d = ST_QDIV;
			ST_QDIV: begin
				if (div_rsp.done) begin
					state_d = ST_MDRY;
				end
			end
			ST_MDRY: state_d = ST_MWET;
			ST_MWET: state_d = ST_MSUM;
			ST_MSUM: state_d = ST_MRND;
			ST_MRND: state_d = ST_LPRE;
			ST_LPRE: state_d = ST_LDIV;
			ST_LDIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, registers, hold counter and held value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			hold_factor_q <= RST_HOLD_FACTOR;
			bit_depth_q   <= RST_BIT_DEPTH;
			dry_gain_q    <= RST_DRY_GAIN;
			wet_gain_q    <= RST_WET_GAIN;
			hold_count_q  <= '0;
			held_q        <= '0;
			dst_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HOLD_FACTOR: hold_factor_q <= cfg_data;
					REG_BIT_DEPTH:   bit_depth_q   <= cfg_data[DEPTH_W-1:0];
					REG_DRY_GAIN:    dry_gain_q    <= cfg_data;
					REG_WET_GAIN:    wet_gain_q    <= cfg_data;
					default: ;
				endcase
			end
			if (src_take) begin
				if (hold_count_q == '0) begin
					hold_count_q <= (hold_factor_q == '0) ? '0 : hold_factor_q - 1'b1;
				end else begin
					hold_count_q <= hold_count_q - 1'b1;
				end
			end
			if (state_q == ST_QDIV && div_rsp.done) begin
				held_q <= div_rsp.quo[DIV_QW-1] ? Q23_MAX
					: {~div_rsp.quo[SAMPLE_W-1], div_rsp.quo[SAMPLE_W-2:0]};
			end
			if (state_q == ST_DONE && out_free) begin
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (src_take) begin
			x_q  <= sample_in;
			lv_q <= lv;
		end
		if (state_q == ST_QMUL || state_q == ST_MDRY || state_q == ST_MWET) begin
			prod_q <= prod;
		end
		if (state_q == ST_MWET) begin
			acc_q <= prod_q[ACC_W-1:0];
		end else if (state_q == ST_MSUM) begin
			acc_q <= acc_q + prod_q[ACC_W-1:0];
		end
		if (state_q == ST_MRND) begin
			neg_q <= acc_q[ACC_W-1];
			m_q   <= rnd[39:15];
		end
		if (state_q == ST_LDIV && div_rsp.done) begin
			res_q <= res;
		end
		if (state_q == ST_DONE && out_free) begin
			sample_out_q <= res_q;
		end
	end

	// An expired hold counter sends the sample through the quantizer.
	a_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(src_take && hold_count_q == '0) |=> (state_q == ST_QMUL))
		else $error("held value not refreshed on an expired hold count");

	// The quantizer division finishes straight into the mix.
	a_quant_to_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QDIV && div_rsp.done) |=> (state_q == ST_MDRY))
		else $error("sequencer skipped the mix after quantizing");

	// The divider is never restarted while it runs.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	// The limiter keeps every result below 5/3 of the Q2.22 unit.
	a_out_peak: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (sample_out <= OUT_PEAK && sample_out >= -OUT_PEAK))
		else $error("limited sample out of range");

endmodule
